>>> rtl/core/dc_pkg.sv
// Shared types, constants and the microcode program of the divisor counter.
package dc_pkg;

  // Result width and the fixed trial divisors.
  localparam int TOTAL_W     = 11;
  localparam int FIRST_PRIME = 2;
  localparam int NEXT_PRIME  = 3;
  localparam int WHEEL_START = 5;
  localparam int WHEEL_STEP  = 6;

  localparam int STEP_W = 4;

  // Datapath operations.
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_START = 4'd2;
  localparam logic [3:0] OP_STRIP = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_ADV   = 4'd5;
  localparam logic [3:0] OP_LEFT  = 4'd6;
  localparam logic [3:0] OP_EMIT  = 4'd7;
  localparam logic [3:0] OP_ZERO  = 4'd8;

  // Jump conditions.
  localparam logic [3:0] C_NEVER   = 4'd0;
  localparam logic [3:0] C_ALWAYS  = 4'd1;
  localparam logic [3:0] C_NOACC   = 4'd2;
  localparam logic [3:0] C_ZERO    = 4'd3;
  localparam logic [3:0] C_BUSY    = 4'd4;
  localparam logic [3:0] C_EXIT    = 4'd5;
  localparam logic [3:0] C_NDIV    = 4'd6;
  localparam logic [3:0] C_DIVIDES = 4'd7;
  localparam logic [3:0] C_OUTBUSY = 4'd8;

  // Program addresses.
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_ZTEST = 4'd1;
  localparam logic [STEP_W-1:0] S_DIV   = 4'd2;
  localparam logic [STEP_W-1:0] S_WAIT1 = 4'd3;
  localparam logic [STEP_W-1:0] S_BOUND = 4'd4;
  localparam logic [STEP_W-1:0] S_TEST  = 4'd5;
  localparam logic [STEP_W-1:0] S_STRIP = 4'd6;
  localparam logic [STEP_W-1:0] S_WAIT2 = 4'd7;
  localparam logic [STEP_W-1:0] S_AGAIN = 4'd8;
  localparam logic [STEP_W-1:0] S_MUL   = 4'd9;
  localparam logic [STEP_W-1:0] S_ADV   = 4'd10;
  localparam logic [STEP_W-1:0] S_LEFT  = 4'd11;
  localparam logic [STEP_W-1:0] S_HOLD  = 4'd12;
  localparam logic [STEP_W-1:0] S_EMIT  = 4'd13;
  localparam logic [STEP_W-1:0] S_ZERO  = 4'd14;

  typedef struct packed {
    logic [3:0]        op;
    logic [3:0]        cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Control store: when the condition holds the sequencer jumps to the
  // target, otherwise it falls through to the next step.
  function automatic uword_t ucode(input logic [STEP_W-1:0] addr);
    uword_t w;
    case (addr)
      S_IDLE:  w = '{OP_LOAD,  C_NOACC,   S_IDLE};
      S_ZTEST: w = '{OP_NONE,  C_ZERO,    S_ZERO};
      S_DIV:   w = '{OP_START, C_NEVER,   S_IDLE};
      S_WAIT1: w = '{OP_NONE,  C_BUSY,    S_WAIT1};
      S_BOUND: w = '{OP_NONE,  C_EXIT,    S_LEFT};
      S_TEST:  w = '{OP_NONE,  C_NDIV,    S_ADV};
      S_STRIP: w = '{OP_STRIP, C_NEVER,   S_IDLE};
      S_WAIT2: w = '{OP_NONE,  C_BUSY,    S_WAIT2};
      S_AGAIN: w = '{OP_NONE,  C_DIVIDES, S_STRIP};
      S_MUL:   w = '{OP_MUL,   C_NEVER,   S_IDLE};
      S_ADV:   w = '{OP_ADV,   C_ALWAYS,  S_DIV};
      S_LEFT:  w = '{OP_LEFT,  C_NEVER,   S_IDLE};
      S_HOLD:  w = '{OP_NONE,  C_OUTBUSY, S_HOLD};
      S_EMIT:  w = '{OP_EMIT,  C_ALWAYS,  S_IDLE};
      S_ZERO:  w = '{OP_ZERO,  C_ALWAYS,  S_HOLD};
      default: w = '{OP_NONE,  C_ALWAYS,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/dc_div.sv
// Radix-2 restoring divider giving quotient and remainder, one bit per cycle.
module dc_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH+1:0] diff;
  logic                   fits;

  assign diff = {1'b0, acc_r, quo_r[VALUE_WIDTH-1]} - {2'b00, dvs_r};
  assign fits = ~diff[VALUE_WIDTH+1];

  always_comb begin
    acc_nxt = acc_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (start) begin
      acc_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(VALUE_WIDTH);
    end else if (cnt_r != '0) begin
      acc_nxt = fits ? diff[VALUE_WIDTH-1:0] : {acc_r[VALUE_WIDTH-2:0], quo_r[VALUE_WIDTH-1]};
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = quo_r;
  assign remainder = acc_r;

endmodule

>>> rtl/core/divisor_count.sv
// Divisor counter: number of positive divisors of an unsigned integer.
// Each candidate divisor takes one division in the shared bit-serial divider, each factor
// stripped one more division, and each prime factor found one multiply; a large prime runs
// the trial loop up to its square root, while a zero skips the loop.
// Throughput: one item at a time; the next item is accepted once the result is registered.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle and empties the output.
module divisor_count #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [VALUE_WIDTH-1:0]      in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dc_pkg::TOTAL_W-1:0]  out_divisor_total
);

  localparam int TW  = dc_pkg::TOTAL_W;
  // The exponent plus one of a prime factor is at most VALUE_WIDTH + 1.
  localparam int E_W = $clog2(VALUE_WIDTH + 2);

  // Sequencer state. The step counter addresses the control store and each
  // control word names one datapath operation and one conditional jump.
  logic [dc_pkg::STEP_W-1:0] step_r, step_nxt;
  dc_pkg::uword_t            uw;
  logic                      take;

  // Datapath registers. rem_r holds the part of the value not yet factored,
  // d_r the current trial divisor, e_r the exponent plus one of d_r, and
  // total_r the running product of those terms, kept modulo 2^11.
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [E_W-1:0]         e_r, e_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic                   trial_r, trial_nxt;  // past 2 and 3, on the 6k+-1 wheel
  logic                   gap_r, gap_nxt;      // next wheel step adds 4 when set, else 2
  logic                   out_valid_r, out_valid_nxt;
  logic [TW-1:0]          out_total_r, out_total_nxt;

  logic                   div_start;
  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;
  logic [TW+E_W-1:0]      prod;

  assign uw = dc_pkg::ucode(step_r);

  // Stripping a factor divides the fresh quotient again by the same divisor.
  assign div_start    = (uw.op == dc_pkg::OP_START) || (uw.op == dc_pkg::OP_STRIP);
  assign div_dividend = (uw.op == dc_pkg::OP_STRIP) ? div_quo : rem_r;

  dc_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (d_r),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Only the low bits of the product matter, since the count wraps at 11 bits.
  assign prod = {{E_W{1'b0}}, total_r} * {{TW{1'b0}}, e_r};

  // Jump condition. Trial division on the wheel stops once d exceeds rem/d,
  // which is the same as d*d exceeding rem and needs no wide multiply.
  always_comb begin
    case (uw.cond)
      dc_pkg::C_NEVER:   take = 1'b0;
      dc_pkg::C_ALWAYS:  take = 1'b1;
      dc_pkg::C_NOACC:   take = !in_valid;
      dc_pkg::C_ZERO:    take = (rem_r == '0);
      dc_pkg::C_BUSY:    take = div_busy;
      dc_pkg::C_EXIT:    take = trial_r && (d_r > div_quo);
      dc_pkg::C_NDIV:    take = (div_rem != '0);
      dc_pkg::C_DIVIDES: take = (div_rem == '0);
      dc_pkg::C_OUTBUSY: take = out_valid_r && !out_ready;
      default:           take = 1'b0;
    endcase
  end

  assign step_nxt = take ? uw.target : step_r + 1'b1;

  always_comb begin
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    total_nxt     = total_r;
    trial_nxt     = trial_r;
    gap_nxt       = gap_r;
    out_total_nxt = out_total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (uw.op)
      dc_pkg::OP_LOAD: begin
        rem_nxt   = in_value;
        d_nxt     = VALUE_WIDTH'(dc_pkg::FIRST_PRIME);
        total_nxt = TW'(1);
        trial_nxt = 1'b0;
        gap_nxt   = 1'b0;
      end
      dc_pkg::OP_START: begin
        e_nxt = E_W'(1);
      end
      dc_pkg::OP_STRIP: begin
        rem_nxt = div_quo;
        e_nxt   = e_r + 1'b1;
      end
      dc_pkg::OP_MUL: begin
        total_nxt = prod[TW-1:0];
      end
      dc_pkg::OP_ADV: begin
        // 2 then 3, then 5, 7, 11, 13, ... stepping alternately by 2 and 4.
        if (!trial_r) begin
          if (d_r == VALUE_WIDTH'(dc_pkg::FIRST_PRIME)) begin
            d_nxt = VALUE_WIDTH'(dc_pkg::NEXT_PRIME);
          end else begin
            d_nxt     = VALUE_WIDTH'(dc_pkg::WHEEL_START);
            trial_nxt = 1'b1;
          end
        end else begin
          d_nxt   = d_r + (gap_r ? VALUE_WIDTH'(dc_pkg::WHEEL_STEP - 2) : VALUE_WIDTH'(2));
          gap_nxt = !gap_r;
        end
      end
      dc_pkg::OP_LEFT: begin
        // A leftover above one is a single prime with exponent one.
        if (rem_r > VALUE_WIDTH'(1)) begin
          total_nxt = {total_r[TW-2:0], 1'b0};
        end
      end
      dc_pkg::OP_EMIT: begin
        out_total_nxt = total_r;
        out_valid_nxt = 1'b1;
      end
      dc_pkg::OP_ZERO: begin
        // Zero has no defined divisor count and reports zero.
        total_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= dc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r       <= rem_nxt;
    d_r         <= d_nxt;
    e_r         <= e_nxt;
    total_r     <= total_nxt;
    trial_r     <= trial_nxt;
    gap_r       <= gap_nxt;
    out_total_r <= out_total_nxt;
  end

  assign in_ready          = (step_r == dc_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_divisor_total = out_total_r;

  // The divider only runs while the program waits on it.
  a_div_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (step_r == dc_pkg::S_WAIT1 || step_r == dc_pkg::S_WAIT2))
    else $error("divider busy outside a wait step");

  // Wheel candidates are always odd.
  a_wheel_odd : assert property (@(posedge clk) disable iff (!rst_n)
    (trial_r && step_r != dc_pkg::S_IDLE && step_r != dc_pkg::S_ZTEST) |-> d_r[0])
    else $error("even trial divisor on the wheel");

  // An accepted item starts the program at the zero test.
  a_accept_start : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (step_r == dc_pkg::S_ZTEST))
    else $error("accepted item did not start the program");

  // A new result is only loaded by the emit step.
  a_emit_only : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && !out_ready)) |-> $past(step_r == dc_pkg::S_EMIT))
    else $error("result appeared outside the emit step");

  // The emit step never overwrites a result that is still waiting.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == dc_pkg::S_EMIT) |-> !(out_valid && !out_ready))
    else $error("emit while output still held");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for divisor_count: directed table, then mostly smooth random operands.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 32;

  // One outstanding expectation: the operand that went in and the divisor count it must
  // produce. The operand is kept only so that a mismatch report can name it.
  typedef struct packed {
    logic [VW-1:0]              value;
    logic [dc_pkg::TOTAL_W-1:0] total;
  } due_t;

  // One row of the directed table. When known is set, total is the count read straight
  // off the operand; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic [VW-1:0]              value;
    logic                       known;
    logic [dc_pkg::TOTAL_W-1:0] total;
  } probe_t;

  localparam int PROBES = 20;

  // Operands that exercise the cases worth naming: zero and one, the two fixed primes
  // alone and squared, the composite whose large prime factor sits above the square root of the value,
  // squares of wheel candidates (the loop bound hit with equality), a top-bit-only and an
  // all-ones operand, a value with very many divisors, and leftover primes that survive
  // the whole trial loop. Every operand here keeps the trial loop short.
  probe_t probe_table [0:PROBES-1] = '{
    '{32'd0,          1'b1, 11'd0},
    '{32'd1,          1'b1, 11'd1},
    '{32'd2,          1'b1, 11'd2},
    '{32'd3,          1'b1, 11'd2},
    '{32'd4,          1'b1, 11'd3},
    '{32'd5,          1'b1, 11'd2},
    '{32'd10,         1'b1, 11'd4},
    '{32'd9,          1'b0, 11'd0},
    '{32'd25,         1'b0, 11'd0},
    '{32'd35,         1'b0, 11'd0},
    '{32'd49,         1'b0, 11'd0},
    '{32'd121,        1'b0, 11'd0},
    '{32'd289,        1'b0, 11'd0},
    '{32'h8000_0000,  1'b1, 11'd32},
    '{32'hFFFF_FFFF,  1'b1, 11'd32},
    '{32'hFFFF_0000,  1'b0, 11'd0},
    '{32'd3491888400, 1'b0, 11'd0},
    '{32'd65537,      1'b0, 11'd0},
    '{32'd1000003,    1'b0, 11'd0},
    '{32'd2048006144, 1'b0, 11'd0}
  };

  // Building blocks for random smooth operands. Keeping every prime factor but one small
  // bounds the trial loop, so random items finish far sooner than a large 32-bit prime.
  int unsigned small_primes [0:30] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
    59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [VW-1:0]               in_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [dc_pkg::TOTAL_W-1:0]  out_divisor_total;

  // Side band that travels with each item: a typed-in expectation from the table.
  logic                        in_known = 1'b0;
  logic [dc_pkg::TOTAL_W-1:0]  in_known_total = '0;

  // Idle rates in percent, changed by the stimulus process between phases.
  int unsigned                 in_idle_pct = 0;
  int unsigned                 out_idle_pct = 0;

  due_t                        totals_due [$];
  int unsigned                 fault_count = 0;
  int unsigned                 reported = 0;

  divisor_count #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_divisor_total (out_divisor_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Divisor count by trial division. Every prime factor f is stripped completely and
  // contributes (exponent + 1); factors are tried in the order 2, 3, then 5, 7, 11, 13,
  // ... (alternate steps of 2 and 4). The loop stops once f * f exceeds what is left, and
  // a remainder above one is a single prime that doubles the count. Zero yields zero.
  function automatic logic [dc_pkg::TOTAL_W-1:0] divisor_total_of(input logic [VW-1:0] v);
    longint unsigned rest;
    longint unsigned total;
    longint unsigned f;
    longint unsigned step;
    longint unsigned mult;
    if (v == '0) return '0;
    rest  = v;
    total = 1;
    f     = dc_pkg::FIRST_PRIME;
    step  = 2;
    while (f <= rest / f) begin
      mult = 1;
      while (rest % f == 0) begin
        rest = rest / f;
        mult++;
      end
      total = total * mult;
      if (f == dc_pkg::FIRST_PRIME) begin
        f = dc_pkg::NEXT_PRIME;
      end else if (f == dc_pkg::NEXT_PRIME) begin
        f = dc_pkg::WHEEL_START;
      end else begin
        f    = f + step;
        step = dc_pkg::WHEEL_STEP - step;
      end
    end
    if (rest > 1) total = total * 2;
    return total[dc_pkg::TOTAL_W-1:0];
  endfunction

  // Random operand. Most are products of small primes, often times one extra factor
  // below 2^16 that may be a prime left over after the loop; these reach up to the full
  // 32 bits. The rest are small arbitrary values (noise) and powers of two.
  function automatic logic [VW-1:0] random_operand();
    longint unsigned v;
    longint unsigned p;
    int unsigned     kind;
    int unsigned     picks;
    kind = $urandom_range(0, 99);
    if (kind < 10) return $urandom_range(0, 1 << 20);
    if (kind < 20) return VW'(64'd1 << $urandom_range(0, VW - 1));
    v     = 1;
    picks = $urandom_range(1, 16);
    for (int i = 0; i < picks; i++) begin
      // Nested range skews the choice toward the smallest primes, so exponents grow.
      p = small_primes[$urandom_range(0, $urandom_range(0, 30))];
      if (v * p <= 64'hFFFF_FFFF) v = v * p;
    end
    if ($urandom_range(0, 99) < 40) begin
      p = $urandom_range(2, 65535);
      if (v * p <= 64'hFFFF_FFFF) v = v * p;
    end
    return v[VW-1:0];
  endfunction

  // Offers one item: a random number of idle cycles first (per the current sender rate),
  // then valid with a steady payload until the block takes it. The task returns just
  // after the accepting edge with valid still high, so a following call that does not idle
  // only changes the payload and never drops and raises valid at the same edge.
  task automatic offer(input logic [VW-1:0] v, input logic known,
                       input logic [dc_pkg::TOTAL_W-1:0] total);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= v;
    in_known       <= known;
    in_known_total <= total;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every accepted item has produced its result.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (totals_due.size() != 0) @(negedge clk);
  endtask

  // The receiver changes its mind every cycle, at the rate the current phase sets.
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Everything is sampled at the rising edge, where inputs are already steady and the
  // block's registered outputs still hold their pre-edge values. The expectation for an
  // accepted item is queued before the result check of the same edge, which keeps the
  // order well defined even if a result could leave at once.
  always @(posedge clk) begin : scoreboard
    due_t head;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        head.value = in_value;
        head.total = in_known ? in_known_total : divisor_total_of(in_value);
        totals_due.insert(totals_due.size(), head);
      end
      if (out_valid && out_ready) begin
        if (totals_due.size() == 0) begin
          fault_count++;
          if (reported < 10) begin
            reported++;
            $display("[%0t] result %0d arrived with no item outstanding",
                     $realtime, out_divisor_total);
          end
        end else begin
          head = totals_due.pop_front();
          if (out_divisor_total !== head.total) begin
            fault_count++;
            if (reported < 10) begin
              reported++;
              $display("[%0t] value %0d: divisor_total expected %0d, got %0d",
                       $realtime, head.value, head.total, out_divisor_total);
            end
          end
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then three random phases with different idle
  // patterns. Between phases the sender waits for the block to drain completely.
  initial begin : stimulus
    int unsigned phase_items;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles now and then, the receiver most of the time.
    in_idle_pct  = 35;
    out_idle_pct = 73;
    for (int i = 0; i < PROBES; i++) begin
      offer(probe_table[i].value, probe_table[i].known, probe_table[i].total);
    end
    phase_items = 27;
    for (int i = 0; i < phase_items; i++) offer(random_operand(), 1'b0, '0);
    hold_until_drained();

    // Phase two: the rates swap sides.
    in_idle_pct  = 73;
    out_idle_pct = 35;
    for (int i = 0; i < phase_items; i++) offer(random_operand(), 1'b0, '0);
    hold_until_drained();

    // Phase three: both sides run flat out, items back to back.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int i = 0; i < phase_items; i++) offer(random_operand(), 1'b0, '0);
    hold_until_drained();

    // Give a stray extra result time to show up before the verdict.
    repeat (100) @(posedge clk);
    if (fault_count == 0 && totals_due.size() == 0) begin
      $display("** divisor_count: PASSED **");
    end else begin
      $display("** divisor_count: FAILED **");
    end
    $finish;
  end

  // Watchdog: a correct run finishes well within this time limit.
  initial begin
    #100ms;
    $display("** divisor_count: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/dc_pkg.sv
rtl/core/dc_div.sv
rtl/core/divisor_count.sv
tb/tb_top.sv
